FILE: rtl/h264_rtp_depacketizer_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef H264_RTP_DEPACKETIZER_UNIT_ASSERT_SVH
`define H264_RTP_DEPACKETIZER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define HRD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define HRD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/hrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hrd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SeqW  = 16;
  localparam int unsigned MaxRes = 6;
  localparam int unsigned CntW  = $clog2(MaxRes + 1);

  localparam logic [4:0] NalSlice = 5'd1;
  localparam logic [4:0] NalIdr   = 5'd5;
  localparam logic [4:0] NalSps   = 5'd7;
  localparam logic [4:0] NalPps   = 5'd8;
  localparam logic [4:0] NalFuA   = 5'd28;
  localparam logic [4:0] NalFuB   = 5'd29;

  localparam int unsigned FuStartBit = 7;
  localparam int unsigned FuEndBit   = 6;

  localparam logic [ByteW-1:0] ScZero = 8'h00;
  localparam logic [ByteW-1:0] ScOne  = 8'h01;

  typedef enum logic [1:0] {
    ModeIdle   = 2'd0,
    ModeSingle = 2'd1,
    ModeFrag   = 2'd2,
    ModeDrop   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PosNone   = 2'd0,
    PosHeader = 2'd1,
    PosData   = 2'd2
  } pos_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_present;
    logic             unit_end;
    logic             unit_broken;
  } res_t;

  typedef struct packed {
    logic [CntW-1:0]        count;
    res_t [MaxRes-1:0]      res;
  } plan_t;

  function automatic res_t mk_res(logic [ByteW-1:0] b, logic present, logic fin,
                                  logic broken);
    res_t r;
    r.out_byte     = b;
    r.byte_present = present;
    r.unit_end     = fin;
    r.unit_broken  = broken;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/hrd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface hrd_in_if;
  logic                       valid;
  logic                       ready;
  logic [hrd_pkg::ByteW-1:0]  payload_byte;
  logic                       packet_first;
  logic                       packet_last;
  logic [hrd_pkg::SeqW-1:0]   sequence_number;

  modport source (
    output valid, payload_byte, packet_first, packet_last, sequence_number,
    input  ready
  );
  modport sink (
    input  valid, payload_byte, packet_first, packet_last, sequence_number,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/hrd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface hrd_out_if;
  logic                       valid;
  logic                       ready;
  logic [hrd_pkg::ByteW-1:0]  out_byte;
  logic                       byte_present;
  logic                       unit_end;
  logic                       unit_broken;

  modport source (
    output valid, out_byte, byte_present, unit_end, unit_broken,
    input  ready
  );
  modport sink (
    input  valid, out_byte, byte_present, unit_end, unit_broken,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/hrd_parse.sv
`timescale 1ns / 1ps
`default_nettype none
module hrd_parse (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [hrd_pkg::ByteW-1:0] byte_i,
  input  wire logic                      first_i,
  input  wire logic                      last_i,
  input  wire logic [hrd_pkg::SeqW-1:0]  seq_i,
  output hrd_pkg::plan_t                 plan_o
);
  import hrd_pkg::*;

  logic [SeqW-1:0] prev_seq_q, prev_seq_d;
  mode_e           mode_q, mode_d;
  pos_e            pos_q, pos_d;
  logic [2:0]      ind_q, ind_d;
  logic            fes_q, fes_d;
  logic            open_q, open_d;

  logic [4:0]       nal_type;
  logic [ByteW-1:0] fu_hdr;
  logic             drop;
  logic             four;
  logic [CntW-1:0]  n;

  assign nal_type = byte_i[4:0];
  assign fu_hdr   = {ind_q, byte_i[4:0]};
  assign drop     = (seq_i < prev_seq_q) && (prev_seq_q != '0);

  always_comb begin
    prev_seq_d = prev_seq_q;
    mode_d     = mode_q;
    pos_d      = pos_q;
    ind_d      = ind_q;
    fes_d      = fes_q;
    open_d     = open_q;
    n          = '0;
    four       = 1'b0;
    plan_o     = '0;

    if (first_i) begin
      if (mode_q == ModeSingle && open_d) begin
        plan_o.res[n] = mk_res(ScZero, 1'b0, 1'b1, 1'b1);
        n = n + CntW'(1);
        open_d = 1'b0;
      end
      prev_seq_d = seq_i;
      pos_d      = PosHeader;
      fes_d      = 1'b0;
      if (drop) begin
        mode_d = ModeDrop;
      end else if (nal_type == NalFuA || nal_type == NalFuB) begin
        mode_d = ModeFrag;
        ind_d  = byte_i[7:5];
      end else begin
        mode_d = ModeSingle;
        if (open_d) begin
          plan_o.res[n] = mk_res(ScZero, 1'b0, 1'b1, 1'b1);
          n = n + CntW'(1);
        end
        four = (nal_type == NalSlice) || (nal_type == NalIdr) ||
               (nal_type == NalSps) || (nal_type == NalPps);
        if (four) begin
          plan_o.res[n] = mk_res(ScZero, 1'b1, 1'b0, 1'b0);
          n = n + CntW'(1);
        end
        plan_o.res[n] = mk_res(ScZero, 1'b1, 1'b0, 1'b0);
        n = n + CntW'(1);
        plan_o.res[n] = mk_res(ScZero, 1'b1, 1'b0, 1'b0);
        n = n + CntW'(1);
        plan_o.res[n] = mk_res(ScOne, 1'b1, 1'b0, 1'b0);
        n = n + CntW'(1);
        plan_o.res[n] = mk_res(byte_i, 1'b1, last_i, 1'b0);
        n = n + CntW'(1);
        open_d = !last_i;
      end
    end else if (mode_q == ModeSingle) begin
      plan_o.res[n] = mk_res(byte_i, 1'b1, last_i, 1'b0);
      n = n + CntW'(1);
      open_d = !last_i;
    end else if (mode_q == ModeFrag) begin
      if (pos_q == PosHeader) begin
        pos_d = PosData;
        if (byte_i[FuStartBit]) begin
          if (open_d) begin
            plan_o.res[n] = mk_res(ScZero, 1'b0, 1'b1, 1'b1);
            n = n + CntW'(1);
          end
          four = (fu_hdr[4:0] == NalSlice) || (fu_hdr[4:0] == NalSps) ||
                 (fu_hdr[4:0] == NalPps);
          if (four) begin
            plan_o.res[n] = mk_res(ScZero, 1'b1, 1'b0, 1'b0);
            n = n + CntW'(1);
          end
          plan_o.res[n] = mk_res(ScZero, 1'b1, 1'b0, 1'b0);
          n = n + CntW'(1);
          plan_o.res[n] = mk_res(ScZero, 1'b1, 1'b0, 1'b0);
          n = n + CntW'(1);
          plan_o.res[n] = mk_res(ScOne, 1'b1, 1'b0, 1'b0);
          n = n + CntW'(1);
          plan_o.res[n] = mk_res(fu_hdr, 1'b1, 1'b0, 1'b0);
          n = n + CntW'(1);
          open_d = 1'b1;
        end else if (byte_i[FuEndBit]) begin
          fes_d = 1'b1;
          if (last_i && open_d) begin
            plan_o.res[n] = mk_res(ScZero, 1'b0, 1'b1, 1'b0);
            n = n + CntW'(1);
            open_d = 1'b0;
          end
        end
      end else begin
        plan_o.res[n] = mk_res(byte_i, 1'b1, last_i && fes_q, 1'b0);
        n = n + CntW'(1);
        open_d = !(last_i && fes_q);
      end
    end

    if (last_i) begin
      mode_d = ModeIdle;
    end
    plan_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_seq_q <= '0;
      mode_q     <= ModeIdle;
      pos_q      <= PosNone;
      ind_q      <= '0;
      fes_q      <= 1'b0;
      open_q     <= 1'b0;
    end else if (accept_i) begin
      prev_seq_q <= prev_seq_d;
      mode_q     <= mode_d;
      pos_q      <= pos_d;
      ind_q      <= ind_d;
      fes_q      <= fes_d;
      open_q     <= open_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/hrd_emit.sv
`timescale 1ns / 1ps
`default_nettype none
module hrd_emit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire hrd_pkg::plan_t plan_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output hrd_pkg::res_t       res_o
);
  import hrd_pkg::*;

  res_t [MaxRes-1:0] res_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic              take;

  assign out_valid_o = (idx_q != cnt_q);
  assign take        = out_valid_o && out_ready_i;
  assign in_ready_o  = !out_valid_o || (take && (idx_q + CntW'(1) == cnt_q));
  assign res_o       = out_valid_o ? res_q[idx_q] : '0;

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (accept_i) begin
      cnt_d = plan_i.count;
      idx_d = '0;
    end else if (take) begin
      idx_d = idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      res_q <= plan_i.res;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/h264_rtp_depacketizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Turns RTP payload bytes of H.264 video into an Annex B byte stream, one result per
// cycle on the output side while out_o.ready is high. A payload byte that yields at
// most one result is taken every cycle while the output is ready; a byte that opens
// a NAL unit yields up to six results (a broken mark for a unit left open, a three or
// four byte start code and the byte or rebuilt header), and the input request is
// held off until the result buffer has drained. Late packets by sequence number are
// dropped.
module h264_rtp_depacketizer_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hrd_in_if.sink    in_i,
  hrd_out_if.source out_o
);
  import hrd_pkg::*;

  plan_t plan;
  res_t  res;
  logic  in_ready;
  logic  accept;

  assign accept     = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  hrd_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_i.payload_byte),
    .first_i  (in_i.packet_first),
    .last_i   (in_i.packet_last),
    .seq_i    (in_i.sequence_number),
    .plan_o   (plan)
  );

  hrd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .plan_i      (plan),
    .in_ready_o  (in_ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .res_o       (res)
  );

  assign out_o.out_byte     = res.out_byte;
  assign out_o.byte_present = res.byte_present;
  assign out_o.unit_end     = res.unit_end;
  assign out_o.unit_broken  = res.unit_broken;

endmodule
`default_nettype wire

FILE: rtl/hrd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "h264_rtp_depacketizer_unit_assert.svh"
module hrd_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic [hrd_pkg::ByteW-1:0] out_byte_i,
  input wire logic                      byte_present_i,
  input wire logic                      unit_end_i,
  input wire logic                      unit_broken_i
);
  // A result that waits must keep its byte and end flag until taken.
  `HRD_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_byte_i) && $stable(unit_end_i))
  // A bare result is always an end mark.
  `HRD_ASSERT_IMP(a_bare_is_end, out_valid_i && !byte_present_i, unit_end_i && out_byte_i == '0)
  // A broken mark closes a unit and carries no byte.
  `HRD_ASSERT_IMP(a_broken_mark, out_valid_i && unit_broken_i, unit_end_i && !byte_present_i)
  // No new request is taken while a result is stalled.
  `HRD_ASSERT_IMP(a_stall_blocks, out_valid_i && !out_ready_i, !in_ready_i)
endmodule

bind h264_rtp_depacketizer_unit hrd_checker u_hrd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_byte_i     (out_o.out_byte),
  .byte_present_i (out_o.byte_present),
  .unit_end_i     (out_o.unit_end),
  .unit_broken_i  (out_o.unit_broken)
);
`default_nettype wire

FILE: dv/h264_rtp_depacketizer_unit_chk.sv
`timescale 1ns / 1ps
module h264_rtp_depacketizer_unit_chk
  import hrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  hrd_in_if           in_i,
  hrd_out_if          out_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned results_o
);

  res_t             stream_expected[$];
  logic [SeqW-1:0]  last_seq;
  mode_e            pkt_mode;
  pos_e             hdr_pos;
  logic [2:0]       fu_nri_bits;
  logic             fu_end_flag;
  logic             nal_open;

  task automatic emit(input logic [ByteW-1:0] b, input logic present, input logic fin,
                      input logic broken);
    res_t r;
    r.out_byte     = b;
    r.byte_present = present;
    r.unit_end     = fin;
    r.unit_broken  = broken;
    stream_expected.push_back(r);
  endtask

  task automatic close_broken_unit();
    if (nal_open) begin
      emit('0, 1'b0, 1'b1, 1'b1);
      nal_open = 1'b0;
    end
  endtask

  task automatic emit_start_code(input bit four);
    if (four) begin
      emit(ScZero, 1'b1, 1'b0, 1'b0);
    end
    emit(ScZero, 1'b1, 1'b0, 1'b0);
    emit(ScZero, 1'b1, 1'b0, 1'b0);
    emit(ScOne, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic emit_payload(input logic [ByteW-1:0] b, input logic closing);
    emit(b, 1'b1, closing, 1'b0);
    nal_open = !closing;
  endtask

  task automatic predict_stream(input logic [ByteW-1:0] b, input logic is_first,
                                input logic is_last, input logic [SeqW-1:0] seq);
    logic             late;
    logic [4:0]       nal_t;
    logic [ByteW-1:0] hdr;
    nal_t = b[4:0];
    if (is_first) begin
      if (pkt_mode == ModeSingle) begin
        close_broken_unit();
      end
      late = (seq < last_seq) && (last_seq != '0);
      last_seq = seq;
      hdr_pos = PosHeader;
      fu_end_flag = 1'b0;
      if (late) begin
        pkt_mode = ModeDrop;
      end else if (nal_t == NalFuA || nal_t == NalFuB) begin
        pkt_mode = ModeFrag;
        fu_nri_bits = b[7:5];
      end else begin
        pkt_mode = ModeSingle;
        close_broken_unit();
        emit_start_code(nal_t inside {NalSlice, NalIdr, NalSps, NalPps});
        emit_payload(b, is_last);
      end
    end else if (pkt_mode == ModeSingle) begin
      emit_payload(b, is_last);
    end else if (pkt_mode == ModeFrag) begin
      if (hdr_pos == PosHeader) begin
        hdr_pos = PosData;
        if (b[FuStartBit]) begin
          hdr = {fu_nri_bits, nal_t};
          close_broken_unit();
          emit_start_code(nal_t inside {NalSlice, NalSps, NalPps});
          emit(hdr, 1'b1, 1'b0, 1'b0);
          nal_open = 1'b1;
        end else if (b[FuEndBit]) begin
          fu_end_flag = 1'b1;
          if (is_last && nal_open) begin
            emit('0, 1'b0, 1'b1, 1'b0);
            nal_open = 1'b0;
          end
        end
      end else begin
        emit_payload(b, is_last && fu_end_flag);
      end
    end
    if (is_last) begin
      pkt_mode = ModeIdle;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      stream_expected.delete();
      last_seq    = '0;
      pkt_mode    = ModeIdle;
      hdr_pos     = PosNone;
      fu_nri_bits = '0;
      fu_end_flag = 1'b0;
      nal_open    = 1'b0;
      pending_o  <= 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        predict_stream(in_i.payload_byte, in_i.packet_first, in_i.packet_last,
                       in_i.sequence_number);
      end
      if (out_i.valid && out_i.ready) begin
        got.out_byte     = out_i.out_byte;
        got.byte_present = out_i.byte_present;
        got.unit_end     = out_i.unit_end;
        got.unit_broken  = out_i.unit_broken;
        results_o <= results_o + 1;
        if (stream_expected.size() == 0) begin
          if (mismatches_o < 10) begin
            $display("[%0t] unexpected result: byte %02h present %0b end %0b broken %0b",
                     $time, got.out_byte, got.byte_present, got.unit_end,
                     got.unit_broken);
          end
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = stream_expected.pop_front();
          if (got.out_byte !== want.out_byte || got.byte_present !== want.byte_present ||
              got.unit_end !== want.unit_end || got.unit_broken !== want.unit_broken) begin
            if (mismatches_o < 10) begin
              $display("[%0t] result mismatch: expected byte %02h present %0b end %0b %s",
                       $time, want.out_byte, want.byte_present, want.unit_end,
                       $sformatf("broken %0b", want.unit_broken));
              $display("    got byte %02h present %0b end %0b broken %0b",
                       got.out_byte, got.byte_present, got.unit_end, got.unit_broken);
            end
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      pending_o <= stream_expected.size();
    end
  end

endmodule

FILE: dv/h264_rtp_depacketizer_unit_tb.sv
`timescale 1ns / 1ps
module h264_rtp_depacketizer_unit_tb;
  import hrd_pkg::*;

  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned PacketBytes = 150;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned      mismatches;
  int unsigned      pending;
  int unsigned      results;
  int unsigned      burst_left;
  int unsigned      idle_cycles;
  int unsigned      pkt_count;
  int unsigned      pkt_bytes;
  int unsigned      holds_done;
  logic [SeqW-1:0]  seq_now;
  logic [ByteW-1:0] body[$];

  always #2 clk_i = ~clk_i;

  hrd_in_if  in_if();
  hrd_out_if out_if();

  h264_rtp_depacketizer_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  h264_rtp_depacketizer_unit_chk u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results)
  );

  task automatic put_byte(input logic [ByteW-1:0] b, input logic is_first,
                          input logic is_last, input logic [SeqW-1:0] seq);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_if.valid           <= 1'b1;
    in_if.payload_byte    <= b;
    in_if.packet_first    <= is_first;
    in_if.packet_last     <= is_last;
    in_if.sequence_number <= seq;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic put_packet(input logic [SeqW-1:0] seq, input bit closed);
    for (int i = 0; i < body.size(); i++) begin
      put_byte(body[i], i == 0, closed && (i == body.size() - 1),
               (i == 0) ? seq : SeqW'($urandom));
    end
    pkt_count++;
    pkt_bytes += body.size();
  endtask

  task automatic put_short(input logic [SeqW-1:0] seq, input int unsigned len,
                           input logic [23:0] bytes, input bit closed);
    body.delete();
    for (int i = 0; i < len; i++) begin
      body.push_back(bytes[8 * (len - 1 - i) +: 8]);
    end
    put_packet(seq, closed);
  endtask

  task automatic add_random_bytes(input int unsigned lo, input int unsigned hi);
    repeat ($urandom_range(lo, hi)) body.push_back(ByteW'($urandom));
  endtask

  function automatic logic [4:0] pick_nal_type(input bit for_fu);
    logic [4:0] t;
    case ($urandom_range(0, 5))
      0: t = NalSlice;
      1: t = NalIdr;
      2: t = NalSps;
      3: t = NalPps;
      default: t = 5'($urandom_range(0, 31));
    endcase
    if (!for_fu && (t == NalFuA || t == NalFuB)) begin
      t = 5'($urandom_range(0, 27));
    end
    return t;
  endfunction

  function automatic logic [SeqW-1:0] pick_seq();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 82) begin
      seq_now = seq_now + 1'b1;
    end else if (r < 92) begin
      seq_now = seq_now - SeqW'($urandom_range(1, 4));
    end else if (r < 95) begin
      seq_now = '0;
    end else if (r < 97) begin
      seq_now = '1;
    end else begin
      seq_now = SeqW'($urandom);
    end
    return seq_now;
  endfunction

  // A long hold-off lets the result buffer fill so that requests back up on the input.
  initial begin : result_sink
    int unsigned taken;
    int unsigned cyc;
    int unsigned hold_left;
    int unsigned pattern;
    taken = 0;
    cyc = 0;
    hold_left = 0;
    pattern = 0;
    holds_done = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        taken++;
      end
      cyc++;
      if (cyc % 48 == 0) begin
        pattern = $urandom_range(0, 3);
      end
      if (hold_left == 0 && holds_done < 2 && taken >= 40 + 120 * holds_done) begin
        hold_left = 200;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (pattern)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 9) >= 3);
          2: out_if.ready <= (cyc % 3 == 0);
          default: out_if.ready <= ($urandom_range(0, 9) >= 7);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("No request moved for %0d cycles.", StallLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned      kind;
    int unsigned      mids;
    logic [ByteW-1:0] ind;
    logic [4:0]       fu_t;
    burst_left = 0;
    pkt_count = 0;
    pkt_bytes = 0;
    seq_now = '0;
    in_if.valid           <= 1'b0;
    in_if.payload_byte    <= '0;
    in_if.packet_first    <= 1'b0;
    in_if.packet_last     <= 1'b0;
    in_if.sequence_number <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    put_byte(8'hFF, 1'b0, 1'b1, 16'hFFFF);
    put_short(16'd1, 1, 24'h65, 1'b1);
    put_short(16'd3, 2, 24'h67FF, 1'b0);
    put_short(16'd4, 1, 24'h41, 1'b1);
    put_short(16'd5, 3, 24'h7C85AA, 1'b1);
    put_short(16'd6, 3, 24'h7C4500, 1'b1);
    put_short(16'd7, 3, 24'hFDC112, 1'b1);
    put_short(16'd8, 1, 24'h68, 1'b1);
    put_short(16'd9, 2, 24'h1C40, 1'b1);
    put_short(16'd10, 3, 24'h1C3F33, 1'b1);
    put_short(16'd11, 2, 24'h1C40, 1'b1);
    put_short(16'd12, 1, 24'h5D, 1'b1);
    put_short(16'd5, 2, 24'h6501, 1'b1);
    put_short(16'd0, 1, 24'h09, 1'b1);
    put_short(16'hFFFF, 1, 24'h09, 1'b1);
    seq_now = 16'hFFFF;

    while (pkt_bytes < PacketBytes) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        body.delete();
        body.push_back({3'($urandom), pick_nal_type(1'b0)});
        add_random_bytes(0, 5);
        put_packet(pick_seq(), $urandom_range(0, 11) != 0);
      end else if (kind < 90) begin
        ind  = {3'($urandom), ($urandom_range(0, 1) != 0) ? NalFuB : NalFuA};
        fu_t = pick_nal_type(1'b1);
        mids = $urandom_range(0, 2);
        body.delete();
        body.push_back(ind);
        body.push_back({1'b1, 1'($urandom_range(0, 9) == 0), 1'($urandom), fu_t});
        add_random_bytes(0, 3);
        put_packet(pick_seq(), $urandom_range(0, 19) != 0);
        repeat (mids) begin
          body.delete();
          body.push_back(ind);
          body.push_back({2'b00, 1'($urandom), fu_t});
          add_random_bytes(1, 4);
          put_packet(pick_seq(), 1'b1);
        end
        if ($urandom_range(0, 6) != 0) begin
          body.delete();
          body.push_back(ind);
          body.push_back({2'b01, 1'($urandom), fu_t});
          add_random_bytes(0, 3);
          put_packet(pick_seq(), 1'b1);
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          put_byte(ByteW'($urandom), 1'b0, $urandom_range(0, 3) == 0, SeqW'($urandom));
        end
      end
    end
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d packets, %0d payload bytes, with late, cut-short and unfinished units;",
             pkt_count, pkt_bytes);
    $display("compared %0d results across %0d long output hold-offs.", results, holds_done);
    if (pending != 0) begin
      $display("%0d expected results never arrived.", pending);
    end
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
